// File: rtl/wsfla_pkg.sv
package wsfla_pkg;

  // Field widths of one command and one result.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned NUM_W    = 5;
  localparam int unsigned STATUS_W = 2;

  // A list command emits at most this many results.
  localparam int unsigned MAX_RESULTS = 32;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIST  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_USED   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

// File: rtl/wsfla_ram.sv
module wsfla_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/watch_slot_free_list_allocator_unit.sv
// Slot allocator over a pool of SLOTS numbered slots, kept as a linked free
// list and a linked in-use list in two single-port-write memories (links and
// values). After reset the block runs an initialization sweep, one entry a
// cycle, and holds busy high until it is done. A command is taken when start
// is high and busy is low. Allocate reads the free head and then moves it to
// the in-use list; free walks the in-use links, one link per cycle, and then
// relinks a found slot; list gives one result per cycle. Every result is
// shown for exactly one cycle with result_valid_o and cannot be stalled, so
// the receiver must take it in that cycle. The last result of a command has
// last_o set.
module watch_slot_free_list_allocator_unit
  import wsfla_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [NUM_W-1:0]    number_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [NUM_W-1:0]    slot_o,
  output logic [VALUE_W-1:0]  stored_o,
  output logic                last_o
);

  // Pointer width holds slot numbers plus the null marker SLOTS.
  localparam int unsigned PW    = $clog2(SLOTS + 1);
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned LIMIT = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;
  localparam int unsigned KW    = $clog2(LIMIT);
  localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

  localparam logic [2:0] ST_INIT      = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_ALLOC     = 3'd2;
  localparam logic [2:0] ST_FREE_WALK = 3'd3;
  localparam logic [2:0] ST_FREE_FIX  = 3'd4;
  localparam logic [2:0] ST_LIST      = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [PW-1:0]      init_q, init_d;
  logic [PW-1:0]      free_head_q, free_head_d;
  logic [PW-1:0]      used_head_q, used_head_d;
  logic [PW-1:0]      cur_q, cur_d;
  logic [PW-1:0]      prev_q, prev_d;
  logic [AW-1:0]      steps_q, steps_d;
  logic [KW-1:0]      k_q, k_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [NUM_W-1:0]   num_q, num_d;

  logic                result_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [NUM_W-1:0]    slot_q;
  logic [VALUE_W-1:0]  stored_q;
  logic                last_q;

  // Memory ports.
  logic [AW-1:0]      raddr;
  logic               link_we;
  logic [AW-1:0]      link_waddr;
  logic [PW-1:0]      link_wdata;
  logic [PW-1:0]      link_rdata;
  logic               val_we;
  logic [AW-1:0]      val_waddr;
  logic [VALUE_W-1:0] val_wdata;
  logic [VALUE_W-1:0] val_rdata;

  // Result being produced this cycle.
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [PW-1:0]       emit_slot;
  logic [VALUE_W-1:0]  emit_stored;
  logic                emit_last;

  logic [PW-1:0]       nx;
  logic                nx_null;
  logic                free_null;
  logic                used_null;
  logic                prev_null;
  logic                cur_match;
  logic                list_fin;
  logic [PW+NUM_W-1:0] slot_ext;

  wsfla_ram #(
    .DEPTH (SLOTS),
    .WIDTH (PW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (link_rdata)
  );

  wsfla_ram #(
    .DEPTH (SLOTS),
    .WIDTH (VALUE_W)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  // A link read back from memory that lies out of range counts as null.
  assign nx_null   = (link_rdata >= NULL_PTR);
  assign nx        = nx_null ? NULL_PTR : link_rdata;
  assign free_null = (free_head_q >= NULL_PTR);
  assign used_null = (used_head_q >= NULL_PTR);
  assign prev_null = (prev_q >= NULL_PTR);
  assign cur_match = ({{NUM_W{1'b0}}, cur_q} == {{PW{1'b0}}, num_q});
  assign list_fin  = nx_null || (k_q == KW'(LIMIT - 1));

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    k_d         = k_q;
    value_d     = value_q;
    num_d       = num_q;

    raddr       = cur_q[AW-1:0];
    link_we     = 1'b0;
    link_waddr  = cur_q[AW-1:0];
    link_wdata  = free_head_q;
    val_we      = 1'b0;
    val_waddr   = cur_q[AW-1:0];
    val_wdata   = '0;

    emit        = 1'b0;
    emit_status = STATUS_OK;
    emit_slot   = '0;
    emit_stored = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      ST_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_q[AW-1:0];
        link_wdata = init_q + PW'(1);
        val_we     = 1'b1;
        val_waddr  = init_q[AW-1:0];
        if (init_q == PW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          init_d = init_q + PW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          unique case (func_i)
            FUNC_ALLOC: begin
              if (free_null) begin
                emit        = 1'b1;
                emit_status = STATUS_NO_FREE;
              end else begin
                raddr   = free_head_q[AW-1:0];
                cur_d   = free_head_q;
                value_d = value_i;
                state_d = ST_ALLOC;
              end
            end
            FUNC_FREE: begin
              if (used_null) begin
                emit        = 1'b1;
                emit_status = STATUS_NO_USED;
              end else begin
                raddr   = used_head_q[AW-1:0];
                cur_d   = used_head_q;
                prev_d  = NULL_PTR;
                steps_d = '0;
                num_d   = number_i;
                state_d = ST_FREE_WALK;
              end
            end
            FUNC_LIST: begin
              if (used_null) begin
                emit        = 1'b1;
                emit_status = STATUS_NO_USED;
              end else begin
                raddr   = used_head_q[AW-1:0];
                cur_d   = used_head_q;
                k_d     = '0;
                state_d = ST_LIST;
              end
            end
            default: begin
              // Unused function code: the command is dropped.
            end
          endcase
        end
      end

      ST_ALLOC: begin
        // Pop the free head and push it onto the in-use list.
        free_head_d = nx;
        link_we     = 1'b1;
        link_wdata  = used_head_q;
        val_we      = 1'b1;
        val_wdata   = value_q;
        used_head_d = cur_q;
        emit        = 1'b1;
        emit_slot   = cur_q;
        emit_stored = value_q;
        state_d     = ST_IDLE;
      end

      ST_FREE_WALK: begin
        if (cur_match) begin
          // Unlink the slot from its predecessor or from the head.
          if (prev_null) begin
            used_head_d = nx;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_q[AW-1:0];
            link_wdata = nx;
          end
          state_d = ST_FREE_FIX;
        end else if (nx_null || (steps_q == AW'(SLOTS - 1))) begin
          emit        = 1'b1;
          emit_status = STATUS_NOT_FOUND;
          state_d     = ST_IDLE;
        end else begin
          prev_d  = cur_q;
          cur_d   = nx;
          steps_d = steps_q + AW'(1);
          raddr   = nx[AW-1:0];
        end
      end

      ST_FREE_FIX: begin
        // Push the freed slot onto the free list and clear its value.
        link_we     = 1'b1;
        link_wdata  = free_head_q;
        val_we      = 1'b1;
        free_head_d = cur_q;
        emit        = 1'b1;
        emit_slot   = cur_q;
        state_d     = ST_IDLE;
      end

      ST_LIST: begin
        emit        = 1'b1;
        emit_slot   = cur_q;
        emit_stored = val_rdata;
        emit_last   = list_fin;
        if (list_fin) begin
          state_d = ST_IDLE;
        end else begin
          cur_d = nx;
          k_d   = k_q + KW'(1);
          raddr = nx[AW-1:0];
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign slot_ext = {{NUM_W{1'b0}}, emit_slot};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      init_q         <= '0;
      free_head_q    <= '0;
      used_head_q    <= NULL_PTR;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      init_q         <= init_d;
      free_head_q    <= free_head_d;
      used_head_q    <= used_head_d;
      result_valid_q <= emit;
    end
  end

  // Walk registers and the result register.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    steps_q  <= steps_d;
    k_q      <= k_d;
    value_q  <= value_d;
    num_q    <= num_d;
    status_q <= emit_status;
    slot_q   <= slot_ext[NUM_W-1:0];
    stored_q <= emit_stored;
    last_q   <= emit_last;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign stored_o       = stored_q;
  assign last_o         = last_q;

endmodule
